@@ design/gemm_pkg.sv @@
`default_nettype none
package gemm_pkg;

  localparam int DIM    = 8;
  localparam int IDX_W  = $clog2(DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = DIM * DIM;
  localparam int DIM_W  = 4;
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 36;
  localparam int OPY_W  = ACC_W - 8;
  localparam int PROD_W = VAL_W + OPY_W;
  localparam int TOT_W  = PROD_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_C = 2'd2,
    CMD_START  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSPOSE_A = 3'd0,
    CFG_TRANSPOSE_B = 3'd1,
    CFG_ROWS_M      = 3'd2,
    CFG_COLS_N      = 3'd3,
    CFG_INNER_K     = 3'd4,
    CFG_ALPHA_GAIN  = 3'd5,
    CFG_BETA_GAIN   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ALPHA,
    S_BETA,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_AB,
    MUL_ALPHA,
    MUL_BETA
  } mul_sel_t;

  typedef struct packed {
    logic                    transpose_a;
    logic                    transpose_b;
    logic [DIM_W-1:0]        rows_m;
    logic [DIM_W-1:0]        cols_n;
    logic [DIM_W-1:0]        inner_k;
    logic signed [VAL_W-1:0] alpha_gain;
    logic signed [VAL_W-1:0] beta_gain;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    cmd_t                    sel;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] c_addr;
  } store_rd_t;

  typedef struct packed {
    logic     acc_clr;
    logic     acc_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     tot_ld;
    logic     res_ld;
  } mac_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    clamp_dim = (d > DIM_W'(DIM)) ? DIM_W'(DIM) : d;
  endfunction

endpackage
`default_nettype wire

@@ design/gemm_ifs.sv @@
`default_nettype none
interface gemm_in_if;
  import gemm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [IDX_W-1:0]            row;
  logic [IDX_W-1:0]            col;
  logic signed [VAL_W-1:0]     value;
  modport source (output valid, command, row, col, value, input ready);
  modport sink (input valid, command, row, col, value, output ready);
endinterface

interface gemm_out_if;
  import gemm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [IDX_W-1:0]            out_row;
  logic [IDX_W-1:0]            out_col;
  logic signed [VAL_W-1:0]     out_value;
  logic                        last;
  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface gemm_cfg_if;
  import gemm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [CFG_IDX_W-1:0]        index;
  logic [VAL_W-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/matrix_multiply_accumulate_unit.sv @@
// loads of a, b or c are accepted back to back while the sequencer is idle
// start: each c element runs its products through the pipe, then alpha and beta scaling,
// shift and saturation; the run is m*n such elements, each begun once the last is taken;
// the single shared multiplier and the three-deep read/multiply/accumulate pipe set the rate
// rst_n (synchronous, active low) clears the sequencer and restores register defaults;
// the a, b and c stores are not cleared
`default_nettype none
module matrix_multiply_accumulate_unit (
  input  wire         clk,
  input  wire         rst_n,
  gemm_in_if.sink     in_ch,
  gemm_out_if.source  out_ch,
  gemm_cfg_if.sink    cfg_ch
);
  import gemm_pkg::*;

  cfg_t                    cfg_r;
  store_wr_t               wr;
  store_rd_t               rd;
  mac_ctl_t                ctl;
  logic signed [VAL_W-1:0] a_data, b_data, c_data;
  logic signed [VAL_W-1:0] res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transpose_a <= 1'b0;
      cfg_r.transpose_b <= 1'b0;
      cfg_r.rows_m      <= DIM_W'(DIM);
      cfg_r.cols_n      <= DIM_W'(DIM);
      cfg_r.inner_k     <= DIM_W'(DIM);
      cfg_r.alpha_gain  <= VAL_W'(256);
      cfg_r.beta_gain   <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_TRANSPOSE_A: cfg_r.transpose_a <= cfg_ch.data[0];
        CFG_TRANSPOSE_B: cfg_r.transpose_b <= cfg_ch.data[0];
        CFG_ROWS_M:      cfg_r.rows_m      <= cfg_ch.data[DIM_W-1:0];
        CFG_COLS_N:      cfg_r.cols_n      <= cfg_ch.data[DIM_W-1:0];
        CFG_INNER_K:     cfg_r.inner_k     <= cfg_ch.data[DIM_W-1:0];
        CFG_ALPHA_GAIN:  cfg_r.alpha_gain  <= cfg_ch.data;
        CFG_BETA_GAIN:   cfg_r.beta_gain   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  gemm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .res    (res),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .wr     (wr),
    .rd     (rd),
    .ctl    (ctl)
  );

  gemm_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .a_data (a_data),
    .b_data (b_data),
    .c_data (c_data)
  );

  gemm_mac u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .a_data (a_data),
    .b_data (b_data),
    .c_data (c_data),
    .res    (res)
  );

endmodule
`default_nettype wire

@@ design/gemm_store.sv @@
`default_nettype none
module gemm_store (
  input  wire                              clk,
  input  wire gemm_pkg::store_wr_t         wr,
  input  wire gemm_pkg::store_rd_t         rd,
  output logic signed [gemm_pkg::VAL_W-1:0] a_data,
  output logic signed [gemm_pkg::VAL_W-1:0] b_data,
  output logic signed [gemm_pkg::VAL_W-1:0] c_data
);
  import gemm_pkg::*;

  logic signed [VAL_W-1:0] a_mem [0:DEPTH-1];
  logic signed [VAL_W-1:0] b_mem [0:DEPTH-1];
  logic signed [VAL_W-1:0] c_mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.sel)
        CMD_LOAD_A: a_mem[wr.addr] <= wr.data;
        CMD_LOAD_B: b_mem[wr.addr] <= wr.data;
        CMD_LOAD_C: c_mem[wr.addr] <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_data <= a_mem[rd.a_addr];
    b_data <= b_mem[rd.b_addr];
    c_data <= c_mem[rd.c_addr];
  end

endmodule
`default_nettype wire

@@ design/gemm_mac.sv @@
`default_nettype none
module gemm_mac (
  input  wire                                clk,
  input  wire gemm_pkg::mac_ctl_t            ctl,
  input  wire gemm_pkg::cfg_t                cfg,
  input  wire signed [gemm_pkg::VAL_W-1:0]   a_data,
  input  wire signed [gemm_pkg::VAL_W-1:0]   b_data,
  input  wire signed [gemm_pkg::VAL_W-1:0]   c_data,
  output logic signed [gemm_pkg::VAL_W-1:0]  res
);
  import gemm_pkg::*;

  logic signed [VAL_W-1:0]  op_x;
  logic signed [OPY_W-1:0]  op_y;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [TOT_W-1:0]  tot_r;
  logic signed [TOT_W-1:0]  sum_w;
  logic signed [TOT_W-9:0]  shf_w;
  logic signed [VAL_W-1:0]  sat_w;
  logic                     fits_w;

  // one shared multiplier: products, then alpha and beta scaling
  always_comb begin
    case (ctl.mul_sel)
      MUL_AB: begin
        op_x = a_data;
        op_y = {{(OPY_W-VAL_W){b_data[VAL_W-1]}}, b_data};
      end
      MUL_ALPHA: begin
        op_x = cfg.alpha_gain;
        op_y = acc_r[ACC_W-1:8];
      end
      MUL_BETA: begin
        op_x = cfg.beta_gain;
        op_y = {{(OPY_W-VAL_W){c_data[VAL_W-1]}}, c_data};
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  // a zero gain kills its term even if the other operand was never written
  assign prod_w = (op_x == '0) ? $signed({PROD_W{1'b0}}) : op_x * op_y;

  assign sum_w  = tot_r + TOT_W'(prod_r);
  assign shf_w  = sum_w[TOT_W-1:8];
  assign fits_w = (&shf_w[TOT_W-9:VAL_W-1]) | ~(|shf_w[TOT_W-9:VAL_W-1]);
  assign sat_w  = fits_w ? shf_w[VAL_W-1:0]
                : (shf_w[TOT_W-9] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.tot_ld) begin
      tot_r <= TOT_W'(prod_r);
    end
    if (ctl.res_ld) begin
      res <= sat_w;
    end
  end

endmodule
`default_nettype wire

@@ design/gemm_seq.sv @@
`default_nettype none
module gemm_seq (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire gemm_pkg::cfg_t              cfg,
  input  wire signed [gemm_pkg::VAL_W-1:0] res,
  gemm_in_if.sink                          in_ch,
  gemm_out_if.source                       out_ch,
  output gemm_pkg::store_wr_t              wr,
  output gemm_pkg::store_rd_t              rd,
  output gemm_pkg::mac_ctl_t               ctl
);
  import gemm_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [DIM_W-1:0] p_r, p_nxt;
  logic             v1_r, v1_nxt;
  logic             v2_r, v2_nxt;
  logic [DIM_W-1:0] m_eff, n_eff, k_eff;
  logic             issue;
  logic             last_col, last_row;
  logic             in_fire, out_fire;

  assign m_eff = clamp_dim(cfg.rows_m);
  assign n_eff = clamp_dim(cfg.cols_n);
  assign k_eff = clamp_dim(cfg.inner_k);

  assign last_col = ({1'b0, j_r} == n_eff - DIM_W'(1));
  assign last_row = ({1'b0, i_r} == m_eff - DIM_W'(1));
  assign issue    = (state_r == S_MAC) && (p_r < k_eff);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign rd.a_addr = cfg.transpose_a ? {p_r[IDX_W-1:0], i_r} : {i_r, p_r[IDX_W-1:0]};
  assign rd.b_addr = cfg.transpose_b ? {j_r, p_r[IDX_W-1:0]} : {p_r[IDX_W-1:0], j_r};
  assign rd.c_addr = {i_r, j_r};

  assign out_ch.out_row   = i_r;
  assign out_ch.out_col   = j_r;
  assign out_ch.out_value = res;
  assign out_ch.last      = last_row && last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    v1_nxt       = 1'b0;
    v2_nxt       = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    wr.en        = 1'b0;
    wr.sel       = cmd_t'(in_ch.command);
    wr.addr      = {in_ch.row, in_ch.col};
    wr.data      = in_ch.value;
    ctl.acc_clr  = 1'b0;
    ctl.acc_en   = 1'b0;
    ctl.mul_en   = 1'b0;
    ctl.mul_sel  = MUL_AB;
    ctl.tot_ld   = 1'b0;
    ctl.res_ld   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) begin
          if (cmd_t'(in_ch.command) == CMD_START) begin
            if (m_eff != '0 && n_eff != '0) begin
              state_nxt   = S_MAC;
              i_nxt       = '0;
              j_nxt       = '0;
              p_nxt       = '0;
              ctl.acc_clr = 1'b1;
            end
          end else begin
            wr.en = 1'b1;
          end
        end
      end
      S_MAC: begin
        // read, multiply, accumulate: three-deep pipe over the inner index
        if (issue) begin
          p_nxt = p_r + DIM_W'(1);
        end
        v1_nxt      = issue;
        v2_nxt      = v1_r;
        ctl.mul_en  = v1_r;
        ctl.mul_sel = MUL_AB;
        ctl.acc_en  = v2_r;
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = S_ALPHA;
        end
      end
      S_ALPHA: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_ALPHA;
        state_nxt   = S_BETA;
      end
      S_BETA: begin
        ctl.tot_ld  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_BETA;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        ctl.res_ld = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_fire) begin
          wr.en   = 1'b1;
          wr.sel  = CMD_LOAD_C;
          wr.addr = {i_r, j_r};
          wr.data = res;
          if (last_row && last_col) begin
            state_nxt = S_IDLE;
          end else begin
            if (last_col) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
            p_nxt       = '0;
            ctl.acc_clr = 1'b1;
            state_nxt   = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and result channels active together");

  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (p_r <= k_eff))
    else $error("inner index past inner dimension");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last) |=> (state_r == S_IDLE))
    else $error("run did not end after last item");

  a_busy_wr_c: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && state_r != S_IDLE) |-> (wr.sel == CMD_LOAD_C && out_fire))
    else $error("store write during compute other than c write-back");

  a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALPHA) |-> (!v1_r && !v2_r))
    else $error("scaling started with products in flight");

endmodule
`default_nettype wire

@@ tb/matrix_multiply_accumulate_unit_checker.sv @@
`timescale 1ns / 100ps
module matrix_multiply_accumulate_unit_checker
  import gemm_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  gemm_in_if   in_ch,
  gemm_out_if  out_ch,
  gemm_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } c_elem_t;

  cfg_t                    settings;
  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [DEPTH];
  logic signed [VAL_W-1:0] c_mem [DEPTH];
  c_elem_t                 c_expected [$];
  int                      fails;
  int                      seen;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
      c_mem[i] = '0;
    end
    fails       = 0;
    seen        = 0;
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  function automatic int limit_dim(input logic [DIM_W-1:0] d);
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  // new value of c[i][j] from the stores as they stand
  function automatic logic signed [VAL_W-1:0] gemm_element(input int i, input int j,
                                                           input int k);
    longint                  sum;
    longint                  acc;
    longint                  total;
    logic signed [VAL_W-1:0] av;
    logic signed [VAL_W-1:0] bv;
    sum = 0;
    if (settings.alpha_gain != 0) begin
      for (int p = 0; p < k; p++) begin
        av  = settings.transpose_a ? a_mem[p * DIM + i] : a_mem[i * DIM + p];
        bv  = settings.transpose_b ? b_mem[j * DIM + p] : b_mem[p * DIM + j];
        sum = sum + longint'(av) * longint'(bv);
      end
    end
    acc   = sum >>> 8;
    total = longint'(settings.alpha_gain) * acc;
    if (settings.beta_gain != 0)
      total = total + longint'(settings.beta_gain) * longint'(c_mem[i * DIM + j]);
    total = total >>> 8;
    if (total > SAT_HI) return VAL_W'(SAT_HI);
    if (total < SAT_LO) return VAL_W'(SAT_LO);
    return VAL_W'(total);
  endfunction

  task automatic run_product();
    logic signed [VAL_W-1:0] fresh [DEPTH];
    int                      m;
    int                      n;
    int                      k;
    c_elem_t                 e;
    m = limit_dim(settings.rows_m);
    n = limit_dim(settings.cols_n);
    k = limit_dim(settings.inner_k);
    if (m == 0 || n == 0) return;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++)
        fresh[i * DIM + j] = gemm_element(i, j, k);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        c_mem[i * DIM + j] = fresh[i * DIM + j];
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = fresh[i * DIM + j];
        e.last  = (i == m - 1) && (j == n - 1);
        c_expected.push_back(e);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic signed [VAL_W:0] want,
                               input logic signed [VAL_W:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    c_elem_t got;
    c_elem_t want;
    if (!rst_n) begin
      settings.transpose_a = 1'b0;
      settings.transpose_b = 1'b0;
      settings.rows_m      = DIM_W'(DIM);
      settings.cols_n      = DIM_W'(DIM);
      settings.inner_k     = DIM_W'(DIM);
      settings.alpha_gain  = 16'sd256;
      settings.beta_gain   = '0;
      c_expected.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TRANSPOSE_A: settings.transpose_a = cfg_ch.data[0];
          CFG_TRANSPOSE_B: settings.transpose_b = cfg_ch.data[0];
          CFG_ROWS_M:      settings.rows_m      = cfg_ch.data[DIM_W-1:0];
          CFG_COLS_N:      settings.cols_n      = cfg_ch.data[DIM_W-1:0];
          CFG_INNER_K:     settings.inner_k     = cfg_ch.data[DIM_W-1:0];
          CFG_ALPHA_GAIN:  settings.alpha_gain  = cfg_ch.data;
          CFG_BETA_GAIN:   settings.beta_gain   = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.row   = out_ch.out_row;
        got.col   = out_ch.out_col;
        got.value = out_ch.out_value;
        got.last  = out_ch.last;
        if (c_expected.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, actual row %0d col %0d value %0d last %0b",
                   $time, got.row, got.col, got.value, got.last);
        end else begin
          want = c_expected.pop_front();
          seen++;
          compare_field("out_row", want.row, got.row);
          compare_field("out_col", want.col, got.col);
          compare_field("out_value", want.value, got.value);
          compare_field("last", want.last, got.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_LOAD_A: a_mem[{in_ch.row, in_ch.col}] = in_ch.value;
          CMD_LOAD_B: b_mem[{in_ch.row, in_ch.col}] = in_ch.value;
          CMD_LOAD_C: c_mem[{in_ch.row, in_ch.col}] = in_ch.value;
          CMD_START:  run_product();
          default: ;
        endcase
      end
    end
    mismatches  <= fails;
    outstanding <= c_expected.size();
    checked     <= seen;
  end

endmodule

@@ tb/matrix_multiply_accumulate_unit_test.sv @@
`timescale 1ns / 100ps
module matrix_multiply_accumulate_unit_test;
  import gemm_pkg::*;

  localparam int ITEM_TARGET    = 220;
  localparam int DRAIN_CYCLES   = 24;
  localparam int SQUEEZE_CYCLES = 600;
  localparam int QUIET_LIMIT    = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [VAL_W-1:0]     UNITY      = 16'h0100;
  localparam logic [VAL_W-1:0]     Q_MAX      = 16'h7fff;
  localparam logic [VAL_W-1:0]     Q_MIN      = 16'h8000;

  logic clk = 1'b0;
  logic rst_n;

  gemm_in_if  in_ch ();
  gemm_out_if out_ch ();
  gemm_cfg_if cfg_ch ();

  int mismatches;
  int outstanding;
  int checked;
  int items_sent  = 0;
  int starts_sent = 0;
  int jobs_run    = 0;
  bit squeeze_armed = 1'b0;
  bit sender_calm   = 1'b0;
  bit a_written [DEPTH];
  bit b_written [DEPTH];
  bit c_written [DEPTH];

  // shape currently programmed, used to keep every read entry written
  logic             cur_ta;
  logic             cur_tb;
  logic [DIM_W-1:0] cur_m;
  logic [DIM_W-1:0] cur_n;
  logic [DIM_W-1:0] cur_k;

  always #2 clk = ~clk;

  matrix_multiply_accumulate_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  matrix_multiply_accumulate_unit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VAL_W-1:0] pick_q88();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return UNITY;
      2: return Q_MAX;
      3: return Q_MIN;
      4: return VAL_W'($urandom_range(0, 1023) - 512);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // mostly small shapes, now and then empty, oversized or full
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(DIM + 1, 15));
    if (r == 2) return DIM_W'(DIM);
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic int span(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.row     <= row;
    in_ch.col     <= col;
    in_ch.value   <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    case (cmd)
      CMD_LOAD_A: a_written[{row, col}] = 1'b1;
      CMD_LOAD_B: b_written[{row, col}] = 1'b1;
      CMD_LOAD_C: c_written[{row, col}] = 1'b1;
      default: begin
        starts_sent++;
        // the run writes its results back into c
        if (cur_m != 0 && cur_n != 0)
          for (int i = 0; i < span(cur_m); i++)
            for (int j = 0; j < span(cur_n); j++)
              c_written[i * DIM + j] = 1'b1;
      end
    endcase
  endtask

  task automatic send_start();
    send_item(CMD_START, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic random_load();
    cmd_t cmd;
    int   hi;
    cmd = cmd_t'($urandom_range(0, 2));
    hi  = ($urandom_range(0, 3) == 0) ? DIM - 1 : 3;
    send_item(cmd, IDX_W'($urandom_range(0, hi)), IDX_W'($urandom_range(0, hi)), pick_q88());
  endtask

  // load every entry the next start may read that has never been written
  task automatic fill_operands();
    int mm;
    int nn;
    int kk;
    int at;
    mm = span(cur_m);
    nn = span(cur_n);
    kk = span(cur_k);
    for (int i = 0; i < mm; i++)
      for (int p = 0; p < kk; p++) begin
        at = cur_ta ? p * DIM + i : i * DIM + p;
        if (!a_written[at])
          send_item(CMD_LOAD_A, IDX_W'(at / DIM), IDX_W'(at % DIM), pick_q88());
      end
    for (int p = 0; p < kk; p++)
      for (int j = 0; j < nn; j++) begin
        at = cur_tb ? j * DIM + p : p * DIM + j;
        if (!b_written[at])
          send_item(CMD_LOAD_B, IDX_W'(at / DIM), IDX_W'(at % DIM), pick_q88());
      end
    for (int i = 0; i < mm; i++)
      for (int j = 0; j < nn; j++) begin
        at = i * DIM + j;
        if (!c_written[at])
          send_item(CMD_LOAD_C, IDX_W'(i), IDX_W'(j), pick_q88());
      end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(input logic ta, input logic tb, input logic [DIM_W-1:0] m,
                           input logic [DIM_W-1:0] n, input logic [DIM_W-1:0] k,
                           input logic [VAL_W-1:0] alpha, input logic [VAL_W-1:0] beta);
    cfg_write(CFG_TRANSPOSE_A, VAL_W'(ta));
    cfg_write(CFG_TRANSPOSE_B, VAL_W'(tb));
    cfg_write(CFG_ROWS_M, VAL_W'(m));
    cfg_write(CFG_COLS_N, VAL_W'(n));
    cfg_write(CFG_INNER_K, VAL_W'(k));
    cfg_write(CFG_ALPHA_GAIN, alpha);
    cfg_write(CFG_BETA_GAIN, beta);
    cfg_ch.valid <= 1'b0;
    cur_ta = ta;
    cur_tb = tb;
    cur_m  = m;
    cur_n  = n;
    cur_k  = k;
  endtask

  // wait for every expected result, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_job(input bit squeeze);
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] k;
    bit               broken;
    settle();
    m = squeeze ? DIM_W'(DIM) : pick_dim();
    n = squeeze ? DIM_W'(DIM) : pick_dim();
    k = squeeze ? DIM_W'(1) : pick_dim();
    configure(1'($urandom), 1'($urandom), m, n, k, pick_q88(), pick_q88());
    sender_calm = ($urandom_range(0, 3) == 0);
    broken      = !squeeze && ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, 8)) random_load();
    if (!broken) begin
      fill_operands();
      if (squeeze) squeeze_armed = 1'b1;
      send_start();
      // second pass accumulates onto the results just written
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 3)) random_load();
        fill_operands();
        send_start();
      end
    end
    repeat (squeeze ? 12 : $urandom_range(0, 3)) random_load();
    jobs_run++;
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_armed && out_ch.valid) begin
        // long hold-off while the sender keeps offering items
        squeeze_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 29) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("matrix_multiply_accumulate_unit_test failed");
    $finish;
  end

  initial begin : stimulus
    int first_random;
    for (int i = 0; i < DEPTH; i++) begin
      a_written[i] = 1'b0;
      b_written[i] = 1'b0;
      c_written[i] = 1'b0;
    end
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_LOAD_A;
    in_ch.row     <= '0;
    in_ch.col     <= '0;
    in_ch.value   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_TRANSPOSE_A;
    cfg_ch.data   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // products at both limits saturate high and low
    configure(1'b0, 1'b0, 4'd2, 4'd2, 4'd2, UNITY, '0);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, Q_MAX);
    send_item(CMD_LOAD_A, 3'd0, 3'd1, Q_MAX);
    send_item(CMD_LOAD_A, 3'd1, 3'd0, Q_MIN);
    send_item(CMD_LOAD_A, 3'd1, 3'd1, Q_MIN);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, Q_MAX);
    send_item(CMD_LOAD_B, 3'd1, 3'd0, Q_MAX);
    fill_operands();
    send_start();
    // alpha zero, beta one: c comes back unchanged
    settle();
    configure(1'b0, 1'b0, 4'd2, 4'd2, 4'd2, '0, UNITY);
    send_start();
    // both transposed, gains at the extremes
    settle();
    configure(1'b1, 1'b1, 4'd2, 4'd2, 4'd2, Q_MIN, Q_MAX);
    send_start();
    // empty result shapes, and a write to an unused register index
    settle();
    configure(1'b0, 1'b0, 4'd0, 4'd2, 4'd2, UNITY, UNITY);
    send_start();
    settle();
    cfg_write(CFG_UNUSED, VAL_W'($urandom));
    configure(1'b0, 1'b0, 4'd2, 4'd0, 4'd2, UNITY, UNITY);
    send_start();
    // no inner terms: only beta*c remains
    settle();
    configure(1'b0, 1'b0, 4'd2, 4'd2, 4'd0, UNITY, UNITY);
    send_start();
    // rows above the maximum fall back to the maximum
    settle();
    configure(1'b0, 1'b0, 4'd15, 4'd1, 4'd1, UNITY, '0);
    fill_operands();
    send_start();

    first_random = items_sent;
    while (items_sent - first_random < ITEM_TARGET)
      random_job(jobs_run == 0);

    settle();
    $display("covered %0d items in %0d random jobs, %0d starts, %0d results checked",
             items_sent, jobs_run, starts_sent, checked);
    $display("shapes from empty to 8x8 with both transposes and gains at their limits");
    if (mismatches == 0 && outstanding == 0)
      $display("matrix_multiply_accumulate_unit_test passed");
    else
      $display("matrix_multiply_accumulate_unit_test failed");
    $finish;
  end

endmodule
